// ===== rtl/psan_pkg.sv =====
// Shared types and constants for the path component sanitiser.
// Used by psan_ctrl, psan_dp and path_component_sanitiser; no dependencies.
`default_nettype none

package psan_pkg;

    // Buffer sizing
    localparam int BUFFER_DEPTH = 64;
    localparam int CAP_CEILING  = 64;
    localparam int CAP_MAX      = (BUFFER_DEPTH < CAP_CEILING) ? BUFFER_DEPTH : CAP_CEILING;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int CFG_W        = 7;
    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    // Controller states
    typedef enum logic [2:0] {
        ST_FILL,
        ST_PREP,
        ST_FETCH,
        ST_SHOW,
        ST_EMPTY
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic prep;       // load read pointer, clear name state
        logic fetch;      // read buffer at pointer into data register
        logic advance;    // step read pointer
        logic empty_sel;  // drive a zero byte for the empty result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic nonempty;   // at least one byte survives the trim
        logic at_end;     // pointer is on the final surviving byte
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/psan_ctrl.sv =====
// Controller state machine for the path component sanitiser.
// Depends on psan_pkg; drives the handshakes and the datapath commands.
`default_nettype none

module psan_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               out_last,
    output logic               ok,
    input  wire psan_pkg::sts_t sts,
    output psan_pkg::cmd_t     cmd
);
    import psan_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through fill, prepare, fetch and show, or fill, prepare and empty
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = sts.nonempty ? ST_FETCH : ST_EMPTY;
            end
            ST_FETCH:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = sts.at_end ? ST_FILL : ST_FETCH;
                end
            end
            ST_EMPTY:
            begin
                if (out_ready)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Drive handshakes and commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_last      = 1'b0;
        ok            = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_FILL:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid   = 1'b1;
                out_last    = sts.at_end;
                ok          = 1'b1;
                cmd.advance = out_ready && !sts.at_end;
            end
            ST_EMPTY:
            begin
                out_valid     = 1'b1;
                out_last      = 1'b1;
                cmd.empty_sel = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/psan_dp.sv =====
// Datapath for the path component sanitiser: filter, name buffer and trim bounds.
// Depends on psan_pkg; driven by psan_ctrl through cmd_t and sts_t.
`default_nettype none

module psan_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psan_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic [7:0]                  in_char,
    output logic [7:0]                       out_char,
    input  wire psan_pkg::cmd_t              cmd,
    output psan_pkg::sts_t                   sts
);
    import psan_pkg::*;

    logic [7:0]        name_buffer_reg [BUFFER_DEPTH];
    logic [CFG_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              prev_dash_reg;
    logic              prev_dash_next;
    logic              prev_alnum_reg;
    logic              prev_alnum_next;
    logic              ended_reg;
    logic              ended_next;
    logic              have_keep_reg;
    logic              have_keep_next;
    logic [CNT_W-1:0]  first_reg;
    logic [CNT_W-1:0]  first_next;
    logic [CNT_W-1:0]  end_reg;
    logic [CNT_W-1:0]  end_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [7:0]        rd_data_reg;

    logic [CFG_W-1:0]  cap_clip;
    logic [CNT_W-1:0]  limit;
    logic              is_alnum;
    logic              is_kept;
    logic              wr_en;
    logic [7:0]        wr_data;

    // Work out the store limit from the capacity register
    always_comb
    begin
        cap_clip = (cap_reg > CFG_W'(CAP_MAX)) ? CFG_W'(CAP_MAX) : cap_reg;
        limit    = (cap_clip < CFG_W'(2)) ? '0 : CNT_W'(cap_clip - CFG_W'(1));
    end

    // Classify the incoming byte
    always_comb
    begin
        is_alnum = ((in_char >= CHAR_UC_A) && (in_char <= CHAR_UC_Z)) ||
                   ((in_char >= CHAR_LC_A) && (in_char <= CHAR_LC_Z)) ||
                   ((in_char >= CHAR_0)    && (in_char <= CHAR_9));
        is_kept  = is_alnum || (in_char == CHAR_UNDER) || (in_char == CHAR_DASH) ||
                   ((in_char == CHAR_DOT) && (count_reg != '0) && prev_alnum_reg);
    end

    // Filter the byte, update name state and trim bounds
    always_comb
    begin
        count_next      = count_reg;
        prev_dash_next  = prev_dash_reg;
        prev_alnum_next = prev_alnum_reg;
        ended_next      = ended_reg;
        have_keep_next  = have_keep_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        wr_en           = 1'b0;
        wr_data         = CHAR_DASH;
        if (cmd.take && !ended_reg)
        begin
            if (in_char == CHAR_NUL)
            begin
                ended_next = 1'b1;
            end
            else if (count_reg < limit)
            begin
                if (is_kept)
                begin
                    wr_en           = 1'b1;
                    wr_data         = in_char;
                    prev_alnum_next = is_alnum;
                    prev_dash_next  = 1'b0;
                end
                else if (!prev_dash_reg)
                begin
                    wr_en           = 1'b1;
                    prev_dash_next  = 1'b1;
                    prev_alnum_next = 1'b0;
                end
                if (wr_en)
                begin
                    count_next = count_reg + CNT_W'(1);
                    // Track the span that survives the trim
                    if ((wr_data != CHAR_DASH) && (wr_data != CHAR_DOT))
                    begin
                        if (!have_keep_reg)
                        begin
                            first_next = count_reg;
                        end
                        have_keep_next = 1'b1;
                        end_next       = count_reg + CNT_W'(1);
                    end
                end
            end
        end
        if (cmd.prep)
        begin
            count_next      = '0;
            prev_dash_next  = 1'b0;
            prev_alnum_next = 1'b0;
            ended_next      = 1'b0;
            have_keep_next  = 1'b0;
        end
    end

    // Load or step the read pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.prep)
        begin
            ptr_next = first_reg[ADDR_W-1:0];
        end
        else if (cmd.advance)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            count_reg      <= '0;
            prev_dash_reg  <= 1'b0;
            prev_alnum_reg <= 1'b0;
            ended_reg      <= 1'b0;
            have_keep_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            prev_dash_reg  <= prev_dash_next;
            prev_alnum_reg <= prev_alnum_next;
            ended_reg      <= ended_next;
            have_keep_reg  <= have_keep_next;
        end
    end

    // Hold bounds and read pointer
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        end_reg   <= end_next;
        ptr_reg   <= ptr_next;
    end

    // Write the name buffer and register the read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_buffer_reg[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= name_buffer_reg[ptr_reg];
        end
    end

    // Report status and drive the output byte
    always_comb
    begin
        sts.nonempty = have_keep_reg;
        sts.at_end   = ((CNT_W'(ptr_reg) + CNT_W'(1)) == end_reg);
        out_char     = cmd.empty_sel ? CHAR_NUL : rd_data_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/path_component_sanitiser.sv =====
// Top level of the path component sanitiser: joins controller and datapath.
// Depends on psan_pkg, psan_ctrl and psan_dp.
`default_nettype none

// Takes a name one byte per transaction at one byte per cycle and stores the
// cleaned bytes in a 64-entry buffer. On the transaction marked last the block
// passes through a preparing state, then for each result byte fetches it through
// the registered read port of the name buffer and then shows it; an empty name
// gives a single result with ok clear directly after preparing. No new
// input transaction is accepted until the final result has been taken. The
// capacity register may be written at any time and takes effect for the next
// byte stored.
module path_component_sanitiser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psan_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  in_char,
    input  wire logic                        in_last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_char,
    output logic                             out_last,
    output logic                             ok
);
    import psan_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the transactions
    psan_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (out_last),
        .ok        (ok),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Filter, store and read back the name
    psan_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_char   (in_char),
        .out_char  (out_char),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for path_component_sanitiser: directed table, then random names.
// Depends on psan_pkg and the path_component_sanitiser RTL; the expected bytes come from an
// in-bench cleaning predictor, and both handshakes idle and stall at random.
`default_nettype none

module tb;
    import psan_pkg::*;

    localparam int ITEM_TARGET = 380;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_DIRECTED = 25;

    // One stimulus row: optional capacity write before it, the byte, and a typed result
    typedef struct packed {
        logic             cfg;
        logic [CFG_W-1:0] cap;
        logic [7:0]       ch;
        logic             last;
        logic             typed;
        logic [7:0]       e_char;
        logic             e_last;
        logic             e_ok;
    } row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       ok;
    } clean_byte_t;

    localparam row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // empty name ends at once
        '{1'b0, 7'd0, CHAR_NUL, 1'b1, 1'b1, CHAR_NUL, 1'b1, 1'b0},
        '{1'b0, 7'd0, "A",      1'b1, 1'b1, "A",      1'b1, 1'b1},
        // dot kept after a letter
        '{1'b0, 7'd0, "a",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, CHAR_DOT, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "b",      1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        // run of disallowed bytes collapses, leading dash trimmed
        '{1'b0, 7'd0, "~",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, 8'hFF,    1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "Z",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "_",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "9",      1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        // zero byte ends the name, later bytes ignored
        '{1'b0, 7'd0, "q",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, CHAR_NUL, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "z",      1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        // only dashes and dots: trimmed to the empty result
        '{1'b0, 7'd0, CHAR_DASH, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0},
        '{1'b0, 7'd0, CHAR_DOT, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, 8'h80,    1'b1, 1'b1, CHAR_NUL, 1'b1, 1'b0},
        // second dot becomes a dash, trailing trim
        '{1'b0, 7'd0, "0",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, CHAR_DOT, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, CHAR_DOT, 1'b1, 1'b0, 8'h00,    1'b0, 1'b0},
        // capacity below two stores nothing
        '{1'b1, 7'd1, "A",      1'b1, 1'b1, CHAR_NUL, 1'b1, 1'b0},
        // capacity two keeps a single byte
        '{1'b1, 7'd2, "B",      1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "C",      1'b1, 1'b1, "B",      1'b1, 1'b1},
        '{1'b1, 7'd0, "7",      1'b1, 1'b1, CHAR_NUL, 1'b1, 1'b0},
        // capacity above the buffer is clipped
        '{1'b1, 7'd127, "x",    1'b0, 1'b0, 8'h00,    1'b0, 1'b0},
        '{1'b0, 7'd0, "y",      1'b1, 1'b0, 8'h00,    1'b0, 1'b0}
    };

    localparam logic [CFG_W-1:0] PHASE_CAPS [0:6] = '{7'd64, 7'd127, 7'd2, 7'd3, 7'd1, 7'd0, 7'd17};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       in_char;
    logic             in_last;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       out_char;
    logic             out_last;
    logic             ok;

    // Predictor state
    logic [7:0]       name_bytes [BUFFER_DEPTH];
    int               stored_n;
    bit               dash_made;
    bit               kept_alnum;
    bit               name_ended;
    logic [CFG_W-1:0] capacity;

    clean_byte_t      expected_bytes [$];
    int               errors;
    bit               in_burst;
    bit               out_burst;

    path_component_sanitiser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .out_last  (out_last),
        .ok        (ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z) ||
               (c >= CHAR_0 && c <= CHAR_9);
    endfunction

    function automatic bit is_trim(input logic [7:0] c);
        return c == CHAR_DASH || c == CHAR_DOT;
    endfunction

    function automatic int store_limit(input logic [CFG_W-1:0] cap);
        int c;
        c = int'(cap);
        if (c > CAP_MAX)
            c = CAP_MAX;
        if (c < 2)
            return 0;
        return c - 1;
    endfunction

    // Clean one accepted byte; on the last one queue the trimmed name unless typed in
    task automatic clean_byte(input logic [7:0] ch, input bit last, input bit typed);
        bit alnum;
        bit dot_ok;
        int first_i;
        int end_i;
        alnum = is_alnum(ch);
        dot_ok = (ch == CHAR_DOT) && stored_n > 0 && kept_alnum;
        if (!name_ended)
        begin
            if (ch == CHAR_NUL)
                name_ended = 1'b1;
            else if (stored_n < store_limit(capacity))
            begin
                if (alnum || ch == CHAR_UNDER || ch == CHAR_DASH || dot_ok)
                begin
                    name_bytes[stored_n] = ch;
                    stored_n++;
                    kept_alnum = alnum;
                    dash_made = 1'b0;
                end
                else if (!dash_made)
                begin
                    name_bytes[stored_n] = CHAR_DASH;
                    stored_n++;
                    dash_made = 1'b1;
                    kept_alnum = 1'b0;
                end
            end
        end
        if (last)
        begin
            first_i = 0;
            end_i = stored_n;
            while (first_i < end_i && is_trim(name_bytes[first_i]))
                first_i++;
            while (end_i > first_i && is_trim(name_bytes[end_i-1]))
                end_i--;
            if (!typed)
            begin
                if (end_i == first_i)
                    expected_bytes.push_back('{CHAR_NUL, 1'b1, 1'b0});
                else
                    for (int k = first_i; k < end_i; k++)
                        expected_bytes.push_back('{name_bytes[k], k == end_i - 1, 1'b1});
            end
            stored_n = 0;
            dash_made = 1'b0;
            kept_alnum = 1'b0;
            name_ended = 1'b0;
        end
    endtask

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input row_t r);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_char <= r.ch;
        in_last <= r.last;
        do
            @(posedge clk);
        while (!in_ready);
        clean_byte(r.ch, r.last, r.typed);
        if (r.typed)
            expected_bytes.push_back('{r.e_char, r.e_last, r.e_ok});
        @(negedge clk);
    endtask

    // Drain the block, then write the capacity register
    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        capacity = cap;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return 8'(CHAR_UC_A + $urandom_range(0, 25));
        if (r < 35)
            return 8'(CHAR_LC_A + $urandom_range(0, 25));
        if (r < 50)
            return 8'(CHAR_0 + $urandom_range(0, 9));
        if (r < 58)
            return CHAR_UNDER;
        if (r < 66)
            return CHAR_DASH;
        if (r < 76)
            return CHAR_DOT;
        if (r < 78)
            return CHAR_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: stall at random, then check each transaction in order
    initial
    begin
        int stall;
        clean_byte_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 9);
            repeat (stall)
            begin
                out_ready <= 1'b0;
                @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected result char=%02h last=%b ok=%b",
                         $time, out_char, out_last, ok);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %02h actual %02h", $time, want.ch, out_char);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
                    errors++;
                end
                if (ok !== want.ok)
                begin
                    $display("%0t: ok expected %b actual %b", $time, want.ok, ok);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: end the run after too long without any transaction
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus: reset, directed table, then random names across capacity phases
    initial
    begin
        int live;
        int phase;
        int len;
        row_t r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_char = '0;
        in_last = 1'b0;
        errors = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        stored_n = 0;
        dash_made = 1'b0;
        kept_alnum = 1'b0;
        name_ended = 1'b0;
        capacity = CAP_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].cfg)
                set_capacity(DIRECTED_ROWS[i].cap);
            send_item(DIRECTED_ROWS[i]);
        end

        // count every transaction sent, directed rows included
        live = N_DIRECTED;
        phase = 0;
        while (live < ITEM_TARGET)
        begin
            set_capacity(phase < 7 ? PHASE_CAPS[phase] : CFG_W'($urandom_range(0, 127)));
            phase++;
            in_burst = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 8))
            begin
                // mostly short names, now and then one long enough to saturate
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 75) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    r = '0;
                    r.ch = pick_char();
                    r.last = (k == len - 1);
                    live++;
                    send_item(r);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (4 * DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
